// ===== src/bpmf_pkg.sv =====
// ============================================================================
// bpmf_pkg
// Shared constants, codes and types of the byte pattern match finder.
// ============================================================================
`default_nettype none

package bpmf_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned FillW      = $clog2(MaxPattern + 1);
  localparam int unsigned PatIdxW    = $clog2(MaxPattern);
  localparam int unsigned PatternW   = MaxPattern * ByteW;
  localparam int unsigned PosW       = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // one classified byte: a match, an end of string, or both
  typedef struct packed {
    logic            has_match;
    logic            is_last;
    logic [PosW-1:0] position;
    logic [PosW-1:0] total;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/bpmf_ifs.sv =====
// ============================================================================
// bpmf_ifs
// Valid/ready channel interfaces for input bytes, results and configuration.
// ============================================================================
`default_nettype none

interface bpmf_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpmf_pkg::ByteW-1:0]  data_byte;
  logic                        end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface bpmf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [bpmf_pkg::PosW-1:0]   match_position;
  logic [bpmf_pkg::PosW-1:0]   match_total;
  logic                        last_result;

  modport source (output valid, output result_kind, output match_position,
                  output match_total, output last_result, input ready);
  modport sink   (input valid, input result_kind, input match_position,
                  input match_total, input last_result, output ready);
endinterface

interface bpmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpmf_pkg::CfgIdxW-1:0]  index;
  logic [bpmf_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/byte_pattern_match_finder_top.sv =====
// ============================================================================
// byte_pattern_match_finder_top
// Streaming search for a pattern of up to eight bytes, overlapping matches
// included, with a summary count at the end of each string.
// ============================================================================
//
//   channel  dir  transaction payload
//   in_i     in   data_byte[7:0], end_of_string
//   out_o    out  result_kind, match_position[31:0], match_total[31:0], last_result
//   cfg_i    in   index (0 pattern bytes, 1 pattern length), data[63:0]
//
// one byte per cycle while the queue has room; the window compare is a single parallel stage
// a result passes from its byte through the queue and then the output register to out_o
// a byte with a match that also ends the string gives the back end two results, match then summary
// a two-entry queue lets the front keep taking bytes while the output is stalled, until it fills
// reset clears window, counters, pattern and control state at once; no clearing pass
`default_nettype none

module byte_pattern_match_finder_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpmf_in_if.sink   in_i,
  bpmf_out_if.source out_o,
  bpmf_cfg_if.sink  cfg_i
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  bpmf_pkg::entry_t push_entry, pop_entry;

  bpmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  bpmf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  bpmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== src/bpmf_front.sv =====
// ============================================================================
// bpmf_front
// Accepts bytes, shifts the window, compares it against the pattern and
// queues one entry per byte that gives a match or ends the string.
// ============================================================================
`default_nettype none

module bpmf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  bpmf_in_if.sink               in_i,
  bpmf_cfg_if.sink              cfg_i,
  input  wire logic             push_ready_i,
  output logic                  push_valid_o,
  output bpmf_pkg::entry_t      push_entry_o
);

  logic [bpmf_pkg::ByteW-1:0]    win_q [bpmf_pkg::MaxPattern];
  logic [bpmf_pkg::ByteW-1:0]    win_d [bpmf_pkg::MaxPattern];
  logic [bpmf_pkg::FillW-1:0]    fill_q, fill_d;
  logic [bpmf_pkg::PosW-1:0]     pos_q, pos_d;
  logic [bpmf_pkg::PosW-1:0]     cnt_q, cnt_d;
  logic [bpmf_pkg::PatternW-1:0] pat_q;
  logic [bpmf_pkg::LenW-1:0]     len_q;
  logic [bpmf_pkg::LenW-1:0]     len_used;
  logic                          hit;
  logic                          accept;

  assign in_i.ready  = push_ready_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  assign len_used = (len_q > bpmf_pkg::LenW'(bpmf_pkg::MaxPattern)) ?
                    bpmf_pkg::LenW'(bpmf_pkg::MaxPattern) : len_q;

  // shifted window and fill
  always_comb begin
    win_d[0] = in_i.data_byte;
    for (int i = 1; i < bpmf_pkg::MaxPattern; i++) begin
      win_d[i] = win_q[i-1];
    end
    fill_d = (fill_q == bpmf_pkg::FillW'(bpmf_pkg::MaxPattern)) ?
             fill_q : fill_q + bpmf_pkg::FillW'(1);
  end

  // parallel window compare
  always_comb begin
    logic [bpmf_pkg::LenW-1:0] idx;
    hit = (len_used != '0) &&
          ({{(bpmf_pkg::LenW > bpmf_pkg::FillW ? bpmf_pkg::LenW - bpmf_pkg::FillW : 0)
            {1'b0}}, fill_d} >= len_used);
    idx = '0;
    for (int k = 0; k < bpmf_pkg::MaxPattern; k++) begin
      idx = len_used - bpmf_pkg::LenW'(1) - bpmf_pkg::LenW'(k);
      if (bpmf_pkg::LenW'(k) < len_used) begin
        if (win_d[idx[bpmf_pkg::PatIdxW-1:0]] != pat_q[k*bpmf_pkg::ByteW +: bpmf_pkg::ByteW]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    pos_d = (pos_q == '1) ? pos_q : pos_q + bpmf_pkg::PosW'(1);
    cnt_d = (hit && (cnt_q != '1)) ? cnt_q + bpmf_pkg::PosW'(1) : cnt_q;
  end

  assign push_valid_o           = in_i.valid && (hit || in_i.end_of_string);
  assign push_entry_o.has_match = hit;
  assign push_entry_o.is_last   = in_i.end_of_string;
  assign push_entry_o.position  = pos_q - bpmf_pkg::PosW'(len_used) + bpmf_pkg::PosW'(1);
  assign push_entry_o.total     = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpmf_pkg::MaxPattern; i++) begin
        win_q[i] <= '0;
      end
      fill_q <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      if (in_i.end_of_string) begin
        for (int i = 0; i < bpmf_pkg::MaxPattern; i++) begin
          win_q[i] <= '0;
        end
        fill_q <= '0;
        pos_q  <= '0;
        cnt_q  <= '0;
      end else begin
        win_q  <= win_d;
        fill_q <= fill_d;
        pos_q  <= pos_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (bpmf_pkg::cfg_idx_e'(cfg_i.index))
        bpmf_pkg::CFG_PATTERN_BYTES: begin
          pat_q <= cfg_i.data[bpmf_pkg::PatternW-1:0];
        end
        bpmf_pkg::CFG_PATTERN_LENGTH: begin
          len_q <= cfg_i.data[bpmf_pkg::LenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bpmf_fifo.sv =====
// ============================================================================
// bpmf_fifo
// Short entry queue between the classifying front and the result back end.
// ============================================================================
`default_nettype none

module bpmf_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire bpmf_pkg::entry_t  push_entry_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output bpmf_pkg::entry_t       pop_entry_o
);

  bpmf_pkg::entry_t                mem_q [bpmf_pkg::FifoDepth];
  logic [bpmf_pkg::FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [bpmf_pkg::FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [bpmf_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != bpmf_pkg::FifoCntW'(bpmf_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + bpmf_pkg::FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + bpmf_pkg::FifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + bpmf_pkg::FifoCntW'(push) - bpmf_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/bpmf_back.sv =====
// ============================================================================
// bpmf_back
// Turns queued entries into match and summary results through an output
// register; an entry with both gives the match first, then the summary.
// ============================================================================
`default_nettype none

module bpmf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  wire bpmf_pkg::entry_t  pop_entry_i,
  bpmf_out_if.source             out_o
);

  logic                        out_valid_q, out_valid_d;
  logic                        phase_q, phase_d;
  logic                        kind_q, kind_d;
  logic [bpmf_pkg::PosW-1:0]   pos_q, pos_d;
  logic [bpmf_pkg::PosW-1:0]   total_q, total_d;
  logic                        last_q, last_d;
  logic                        load;
  logic                        emit_match;

  assign load        = pop_valid_i && (!out_valid_q || out_o.ready);
  assign emit_match  = pop_entry_i.has_match && !phase_q;
  assign pop_ready_o = load && !(emit_match && pop_entry_i.is_last);

  always_comb begin
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    total_d     = total_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      phase_d     = emit_match && pop_entry_i.is_last;
      total_d     = pop_entry_i.total;
      if (emit_match) begin
        kind_d = bpmf_pkg::KIND_MATCH;
        pos_d  = pop_entry_i.position;
        last_d = !pop_entry_i.is_last;
      end else begin
        kind_d = bpmf_pkg::KIND_SUMMARY;
        pos_d  = '0;
        last_d = 1'b1;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    pos_q   <= pos_d;
    total_q <= total_d;
    last_q  <= last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = kind_q;
  assign out_o.match_position = pos_q;
  assign out_o.match_total    = total_q;
  assign out_o.last_result    = last_q;

endmodule

`default_nettype wire

// ===== src/bpmf_checker.sv =====
// ============================================================================
// bpmf_checker
// Port-level checks on the result channel of the match finder.
// ============================================================================
`default_nettype none

module bpmf_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       result_kind_i,
  input wire logic [bpmf_pkg::PosW-1:0]  match_position_i,
  input wire logic [bpmf_pkg::PosW-1:0]  match_total_i,
  input wire logic                       last_result_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i) &&
    $stable(match_position_i) && $stable(match_total_i) && $stable(last_result_i))
    else $error("result changed while stalled");

  // summary is always final and carries no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == bpmf_pkg::KIND_SUMMARY) |->
    last_result_i && (match_position_i == '0))
    else $error("malformed summary result");

  // a match counts itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == bpmf_pkg::KIND_MATCH) |-> (match_total_i != '0))
    else $error("match with zero total");

  // non-final match is followed straight away by its summary with the same total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (result_kind_i == bpmf_pkg::KIND_MATCH) &&
    !last_result_i |=> out_valid_i && (result_kind_i == bpmf_pkg::KIND_SUMMARY) &&
    (match_total_i == $past(match_total_i)))
    else $error("summary missing after end-of-string match");

endmodule

bind byte_pattern_match_finder_top bpmf_checker u_bpmf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_kind_i    (out_o.result_kind),
  .match_position_i (out_o.match_position),
  .match_total_i    (out_o.match_total),
  .last_result_i    (out_o.last_result)
);

`default_nettype wire
